>>> rtl/sorted_set_table_unit_macros.svh
// assertion macros shared by the sorted set table checks
// no dependencies; each macro expands to one labeled concurrent assertion
`ifndef SORTED_SET_TABLE_UNIT_MACROS_SVH
`define SORTED_SET_TABLE_UNIT_MACROS_SVH

// antecedent implies consequent in the same cycle
`define SST_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("sorted set table check failed");

// antecedent implies consequent in the following cycle
`define SST_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("sorted set table check failed");

`endif

>>> rtl/sst_pkg.sv
// shared types, codes and constants of the sorted set table
// no dependencies; imported by every module of the block
`default_nettype none

package sst_pkg;

  localparam int CAPACITY = 64;
  localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int COUNT_W  = 7;
  localparam int VALUE_W  = 32;

  typedef enum logic [1:0] {
    ACT_INSERT = 2'd0,
    ACT_REMOVE = 2'd1,
    ACT_LOOKUP = 2'd2
  } act_e;

  typedef enum logic [1:0] {
    ST_FALSE = 2'd0,
    ST_TRUE  = 2'd1,
    ST_FULL  = 2'd2
  } status_e;

  typedef struct packed {
    logic [1:0]                action;
    logic signed [VALUE_W-1:0] value;
  } req_t;

  typedef struct packed {
    logic [1:0]         status;
    logic [COUNT_W-1:0] count;
    logic               is_empty;
  } rsp_t;

  typedef enum logic [2:0] {
    CTL_IDLE,
    CTL_SEARCH,
    CTL_DECIDE,
    CTL_INS_SHIFT,
    CTL_REM_SHIFT,
    CTL_RESP
  } ctl_state_e;

  typedef enum logic [2:0] {
    DP_NOP,
    DP_LOAD,
    DP_SEARCH,
    DP_INS_INIT,
    DP_INS_SHIFT,
    DP_REM_INIT,
    DP_REM_SHIFT
  } dp_op_e;

  typedef struct packed {
    dp_op_e op;
  } dp_cmd_t;

  typedef struct packed {
    logic [1:0] action;
    logic       search_done;
    logic       found;
    logic       full;
    logic       ins_done;
    logic       rem_done;
  } dp_stat_t;

  // element count as reported on the result, modulo 2**COUNT_W
  function automatic logic [COUNT_W-1:0] count_field(input logic [CNT_W-1:0] c);
    logic [CNT_W+COUNT_W-1:0] ext;
    ext = {{COUNT_W{1'b0}}, c};
    return ext[COUNT_W-1:0];
  endfunction

endpackage

`default_nettype wire

>>> rtl/sst_dpath.sv
// datapath of the sorted set table: entry memory, walk pointers, element count
// depends on sst_pkg; driven by sst_ctrl through dp_cmd_t, reports dp_stat_t
`default_nettype none

module sst_dpath (
  input  wire               clk_i,
  input  wire               rst_ni,
  input  sst_pkg::req_t     req_i,
  input  sst_pkg::dp_cmd_t  cmd_i,
  output sst_pkg::dp_stat_t stat_o,
  output logic [sst_pkg::CNT_W-1:0] count_o
);
  import sst_pkg::*;

  logic [VALUE_W-1:0]        mem_q [CAPACITY];
  logic signed [VALUE_W-1:0] rdata_q;
  logic [1:0]                action_q;
  logic signed [VALUE_W-1:0] value_q;

  logic [CNT_W-1:0] count_q, count_d;
  logic [CNT_W-1:0] rd_q, rd_d;
  logic [CNT_W-1:0] cmp_q, cmp_d;
  logic [CNT_W-1:0] pos_q, pos_d;
  logic             vld_q, vld_d;
  logic             found_q, found_d;

  logic               re, we;
  logic [IDX_W-1:0]   raddr, waddr;
  logic [VALUE_W-1:0] wdata;

  logic             hit, walk_end;
  logic [CNT_W-1:0] rd_dec, rd_inc, cmp_inc, cmp_dec, pos_inc;

  assign hit      = vld_q && !(rdata_q < value_q);
  assign walk_end = !vld_q && (rd_q >= count_q);
  assign rd_dec   = rd_q - CNT_W'(1);
  assign rd_inc   = rd_q + CNT_W'(1);
  assign cmp_inc  = cmp_q + CNT_W'(1);
  assign cmp_dec  = cmp_q - CNT_W'(1);
  assign pos_inc  = pos_q + CNT_W'(1);

  always_comb begin
    count_d = count_q;
    rd_d    = rd_q;
    cmp_d   = cmp_q;
    pos_d   = pos_q;
    found_d = found_q;
    vld_d   = 1'b0;
    re      = 1'b0;
    raddr   = rd_q[IDX_W-1:0];
    we      = 1'b0;
    waddr   = pos_q[IDX_W-1:0];
    wdata   = value_q;
    case (cmd_i.op)
      DP_LOAD: begin
        rd_d = '0;
      end
      DP_SEARCH: begin
        if (hit) begin
          pos_d   = cmp_q;
          found_d = (rdata_q == value_q);
        end else if (walk_end) begin
          pos_d   = count_q;
          found_d = 1'b0;
        end else if (rd_q < count_q) begin
          re    = 1'b1;
          raddr = rd_q[IDX_W-1:0];
          cmp_d = rd_q;
          rd_d  = rd_inc;
          vld_d = 1'b1;
        end
      end
      DP_INS_INIT: begin
        rd_d = count_q;
      end
      DP_INS_SHIFT: begin
        // move entries up one place, highest first
        if (vld_q) begin
          we    = 1'b1;
          waddr = cmp_inc[IDX_W-1:0];
          wdata = rdata_q;
        end
        if (rd_q > pos_q) begin
          re    = 1'b1;
          raddr = rd_dec[IDX_W-1:0];
          cmp_d = rd_dec;
          rd_d  = rd_dec;
          vld_d = 1'b1;
        end else if (!vld_q) begin
          we      = 1'b1;
          waddr   = pos_q[IDX_W-1:0];
          wdata   = value_q;
          count_d = count_q + CNT_W'(1);
        end
      end
      DP_REM_INIT: begin
        rd_d = pos_inc;
      end
      DP_REM_SHIFT: begin
        // move entries above the hole down one place, lowest first
        if (vld_q) begin
          we    = 1'b1;
          waddr = cmp_dec[IDX_W-1:0];
          wdata = rdata_q;
        end
        if (rd_q < count_q) begin
          re    = 1'b1;
          raddr = rd_q[IDX_W-1:0];
          cmp_d = rd_q;
          rd_d  = rd_inc;
          vld_d = 1'b1;
        end else if (!vld_q) begin
          count_d = count_q - CNT_W'(1);
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      rd_q    <= '0;
      vld_q   <= 1'b0;
    end else begin
      count_q <= count_d;
      rd_q    <= rd_d;
      vld_q   <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmp_q   <= cmp_d;
    pos_q   <= pos_d;
    found_q <= found_d;
    if (cmd_i.op == DP_LOAD) begin
      action_q <= req_i.action;
      value_q  <= req_i.value;
    end
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem_q[waddr] <= wdata;
    end
    if (re) begin
      rdata_q <= mem_q[raddr];
    end
  end

  assign stat_o.action      = action_q;
  assign stat_o.search_done = hit || walk_end;
  assign stat_o.found       = found_q;
  assign stat_o.full        = (count_q >= CNT_W'(CAPACITY));
  assign stat_o.ins_done    = (rd_q <= pos_q) && !vld_q;
  assign stat_o.rem_done    = (rd_q >= count_q) && !vld_q;
  assign count_o            = count_q;

endmodule

`default_nettype wire

>>> rtl/sst_ctrl.sv
// controller of the sorted set table: request sequencing state machine
// depends on sst_pkg; commands sst_dpath and produces the result strobe and status
`default_nettype none

module sst_ctrl (
  input  wire               clk_i,
  input  wire               rst_ni,
  input  wire               start,
  output logic              busy,
  input  sst_pkg::dp_stat_t stat_i,
  output sst_pkg::dp_cmd_t  cmd_o,
  output logic              result_valid_o,
  output logic [1:0]        status_o
);
  import sst_pkg::*;

  ctl_state_e state_q, state_d;
  status_e    status_q, status_d;

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      CTL_IDLE: begin
        if (start) state_d = CTL_SEARCH;
      end
      CTL_SEARCH: begin
        if (stat_i.search_done) state_d = CTL_DECIDE;
      end
      CTL_DECIDE: begin
        case (act_e'(stat_i.action))
          ACT_INSERT: begin
            if (!stat_i.found && !stat_i.full) state_d = CTL_INS_SHIFT;
            else state_d = CTL_RESP;
          end
          ACT_REMOVE: begin
            if (stat_i.found) state_d = CTL_REM_SHIFT;
            else state_d = CTL_RESP;
          end
          default: state_d = CTL_RESP;
        endcase
      end
      CTL_INS_SHIFT: begin
        if (stat_i.ins_done) state_d = CTL_RESP;
      end
      CTL_REM_SHIFT: begin
        if (stat_i.rem_done) state_d = CTL_RESP;
      end
      CTL_RESP: state_d = CTL_IDLE;
      default:  state_d = CTL_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    cmd_o.op       = DP_NOP;
    status_d       = status_q;
    busy           = (state_q != CTL_IDLE);
    result_valid_o = (state_q == CTL_RESP);
    case (state_q)
      CTL_IDLE: begin
        if (start) cmd_o.op = DP_LOAD;
      end
      CTL_SEARCH: cmd_o.op = DP_SEARCH;
      CTL_DECIDE: begin
        status_d = ST_FALSE;
        case (act_e'(stat_i.action))
          ACT_INSERT: begin
            if (stat_i.found) begin
              status_d = ST_FALSE;
            end else if (stat_i.full) begin
              status_d = ST_FULL;
            end else begin
              status_d  = ST_TRUE;
              cmd_o.op  = DP_INS_INIT;
            end
          end
          ACT_REMOVE: begin
            if (stat_i.found) begin
              status_d = ST_TRUE;
              cmd_o.op = DP_REM_INIT;
            end
          end
          ACT_LOOKUP: begin
            if (stat_i.found) status_d = ST_TRUE;
          end
          default: status_d = ST_FALSE;
        endcase
      end
      CTL_INS_SHIFT: cmd_o.op = DP_INS_SHIFT;
      CTL_REM_SHIFT: cmd_o.op = DP_REM_SHIFT;
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= CTL_IDLE;
      status_q <= ST_FALSE;
    end else begin
      state_q  <= state_d;
      status_q <= status_d;
    end
  end

  assign status_o = status_q;

endmodule

`default_nettype wire

>>> rtl/sorted_set_table_unit.sv
// top level of the sorted set table: bounded ascending set of signed 32-bit values
// depends on sst_pkg, sst_ctrl and sst_dpath
//
// usage
//   request channel: drive req_i (action, value) and raise start; the request is
//   transferred at the rising edge where start is high and busy is low
//   result channel: result_valid_o is high for exactly one cycle with result_o
//   (status, count after the request, is_empty); the receiver cannot hold it off
//   actions: insert, remove, lookup; code 3 is a no-op that reports status false
// timing
//   one request at a time; busy stays high from the transfer until the strobe
//   the search walks the entry memory from the bottom, one entry a cycle over
//   its single read port, then a decision state sets the status and picks the next phase
//   insert shifts the entries above the insert point up, remove shifts the
//   entries above the hole down
//   the strobe follows in the cycle after the decision state or the last shift step
//   busy drops the cycle after the strobe, so the next transfer can follow then
// reset
//   asynchronous active low; the set is emptied (count cleared), no clearing pass
//   over the entry memory is needed since only entries below count are read
`default_nettype none

module sorted_set_table_unit (
  input  wire           clk_i,
  input  wire           rst_ni,
  input  wire           start,
  output logic          busy,
  input  sst_pkg::req_t req_i,
  output logic          result_valid_o,
  output sst_pkg::rsp_t result_o
);
  import sst_pkg::*;

  dp_cmd_t          dp_cmd;
  dp_stat_t         dp_stat;
  logic [CNT_W-1:0] count;
  logic [1:0]       status;

  // sequencing of search, decision and shift phases
  sst_ctrl u_ctrl (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .stat_i         (dp_stat),
    .cmd_o          (dp_cmd),
    .result_valid_o (result_valid_o),
    .status_o       (status)
  );

  // entry memory, walk pointers and element count
  sst_dpath u_dpath (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .req_i   (req_i),
    .cmd_i   (dp_cmd),
    .stat_o  (dp_stat),
    .count_o (count)
  );

  // count is already updated by the time the strobe is shown
  assign result_o.status   = status;
  assign result_o.count    = count_field(count);
  assign result_o.is_empty = (count == '0);

endmodule

`default_nettype wire

>>> rtl/sst_checker.sv
// port-level checks of the sorted set table request/result sequencing
// depends on sst_pkg and sorted_set_table_unit_macros.svh; bound to the top level
`default_nettype none
`include "sorted_set_table_unit_macros.svh"

module sst_checker (
  input wire           clk_i,
  input wire           rst_ni,
  input wire           start,
  input wire           busy,
  input wire           result_valid_o,
  input sst_pkg::rsp_t result_o
);
  import sst_pkg::*;

  logic rsp_ok;
  assign rsp_ok = (result_o.status <= ST_FULL) &&
                  (result_o.is_empty == (result_o.count == '0));

  // a transfer makes the block busy
  `SST_ASSERT_NEXT(a_start_busy, clk_i, rst_ni, start && !busy, busy)
  // the result only appears for a transferred request, with a legal status and an is_empty that matches count
  `SST_ASSERT_NOW(a_result_busy, clk_i, rst_ni, result_valid_o, busy && rsp_ok)
  // the strobe lasts one cycle
  `SST_ASSERT_NEXT(a_strobe_single, clk_i, rst_ni, result_valid_o, !result_valid_o)
  // after the result the block is free again
  `SST_ASSERT_NEXT(a_result_idle, clk_i, rst_ni, result_valid_o, !busy)

endmodule

bind sorted_set_table_unit sst_checker u_sst_checker (.*);

`default_nettype wire

>>> sim/tb_top.sv
// regression bench for the sorted set table: directed corner requests, then random
// insert / remove / lookup traffic in fill, churn and drain episodes; needs sst_pkg
// and sorted_set_table_unit
`timescale 1ns / 1ps

module tb_top;
  import sst_pkg::*;

  // action code that the block treats as a no-op
  localparam logic [1:0] ACT_UNUSED = 2'd3;

  localparam logic signed [VALUE_W-1:0] VAL_MIN = 32'sh8000_0000;
  localparam logic signed [VALUE_W-1:0] VAL_MAX = 32'sh7fff_ffff;

  localparam int RANDOM_ITEMS = 1750;
  localparam int TAIL_CYCLES  = 150;

  typedef enum {MIX_FILL, MIX_CHURN, MIX_DRAIN} mix_e;

  // shadow copy of the set plus the queue of results it predicts
  class sorted_set_shadow;
    logic signed [VALUE_W-1:0] held_values[$];
    rsp_t                      expected_rsp[$];
    int unsigned failures;
    int unsigned n_checked;
    int unsigned n_inserted, n_duplicate, n_rejected, n_removed;
    int unsigned n_found, n_missed, n_noop, peak_fill;

    // note an accepted request: update the shadow set and queue its result
    function void note_request(req_t r);
      logic signed [VALUE_W-1:0] v;
      rsp_t want;
      int   pos;
      bit   hit;
      v   = r.value;
      pos = 0;
      while (pos < held_values.size() && held_values[pos] < v) pos++;
      hit = (pos < held_values.size()) && (held_values[pos] == v);
      want.status = ST_FALSE;
      case (r.action)
        ACT_INSERT: begin
          if (hit) begin
            n_duplicate++;
          end else if (held_values.size() >= CAPACITY) begin
            want.status = ST_FULL;
            n_rejected++;
          end else begin
            held_values.insert(pos, v);
            want.status = ST_TRUE;
            n_inserted++;
          end
        end
        ACT_REMOVE: begin
          if (hit) begin
            held_values.delete(pos);
            want.status = ST_TRUE;
            n_removed++;
          end else begin
            n_missed++;
          end
        end
        ACT_LOOKUP: begin
          if (hit) begin
            want.status = ST_TRUE;
            n_found++;
          end else begin
            n_missed++;
          end
        end
        default: n_noop++;
      endcase
      if (held_values.size() > peak_fill) peak_fill = held_values.size();
      want.count    = COUNT_W'(held_values.size());
      want.is_empty = (held_values.size() == 0);
      expected_rsp.push_back(want);
    endfunction

    // compare one result strobe against the oldest prediction
    function void check_result(rsp_t got);
      rsp_t want;
      if (expected_rsp.size() == 0) begin
        $error("result with nothing outstanding: status %0d count %0d is_empty %0d",
               got.status, got.count, got.is_empty);
        failures++;
        return;
      end
      want = expected_rsp.pop_front();
      n_checked++;
      if (got.status !== want.status) begin
        $error("status: expected %0d, actual %0d", want.status, got.status);
        failures++;
      end
      if (got.count !== want.count) begin
        $error("count: expected %0d, actual %0d", want.count, got.count);
        failures++;
      end
      if (got.is_empty !== want.is_empty) begin
        $error("is_empty: expected %0d, actual %0d", want.is_empty, got.is_empty);
        failures++;
      end
    endfunction
  endclass

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;
  logic start  = 1'b0;
  logic busy;
  req_t req_i  = '0;
  logic result_valid_o;
  rsp_t result_o;

  sorted_set_shadow shadow = new();

  // items left in the current stretch without sender gaps
  int calm_left = 0;

  sorted_set_table_unit uut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .req_i          (req_i),
    .result_valid_o (result_valid_o),
    .result_o       (result_o)
  );

  always #2 clk_i = ~clk_i;

  // results cannot be held off, so every strobe is checked at the edge that ends it
  always @(posedge clk_i) begin
    if (rst_ni && result_valid_o) shadow.check_result(result_o);
  end

  function automatic req_t mk_req(logic [1:0] act, logic signed [VALUE_W-1:0] val);
    req_t r;
    r.action = act;
    r.value  = val;
    return r;
  endfunction

  // sender gap before the next request; occasional stretches run back to back
  function automatic int draw_gap();
    if (calm_left > 0) begin
      calm_left--;
      return 0;
    end
    if ($urandom_range(0, 99) < 8) begin
      calm_left = $urandom_range(20, 60);
      return 0;
    end
    return $urandom_range(0, 13);
  endfunction

  // value mix: held entries for hits, a narrow window for collisions,
  // the signed extremes and neighbors of held entries, and full-range noise
  function automatic logic signed [VALUE_W-1:0] pick_value(int held_pct);
    int sel;
    int n;
    sel = $urandom_range(0, 99);
    n   = shadow.held_values.size();
    if (sel < held_pct && n > 0) return shadow.held_values[$urandom_range(0, n - 1)];
    sel = $urandom_range(0, 99);
    if (sel < 40) return VALUE_W'(int'($urandom_range(0, 80)) - 40);
    if (sel < 55) begin
      case ($urandom_range(0, 5))
        0: return VAL_MIN;
        1: return VAL_MIN + 1;
        2: return VAL_MAX;
        3: return VAL_MAX - 1;
        4: return '0;
        default: return '1;
      endcase
    end
    if (sel < 65 && n > 0) begin
      if ($urandom_range(0, 1)) return shadow.held_values[$urandom_range(0, n - 1)] + 1;
      return shadow.held_values[$urandom_range(0, n - 1)] - 1;
    end
    return $urandom;
  endfunction

  function automatic req_t pick_request(mix_e mix);
    int sel;
    sel = $urandom_range(0, 99);
    // a little no-op noise everywhere
    if (sel < 3) return mk_req(ACT_UNUSED, $urandom);
    sel = $urandom_range(0, 99);
    case (mix)
      MIX_FILL: begin
        if (sel < 88) return mk_req(ACT_INSERT, pick_value(10));
        if (sel < 94) return mk_req(ACT_LOOKUP, pick_value(50));
        return mk_req(ACT_REMOVE, pick_value(50));
      end
      MIX_DRAIN: begin
        if (sel < 80) return mk_req(ACT_REMOVE, pick_value(85));
        if (sel < 90) return mk_req(ACT_LOOKUP, pick_value(50));
        return mk_req(ACT_INSERT, pick_value(30));
      end
      default: begin
        if (sel < 40) return mk_req(ACT_INSERT, pick_value(25));
        if (sel < 72) return mk_req(ACT_REMOVE, pick_value(60));
        return mk_req(ACT_LOOKUP, pick_value(60));
      end
    endcase
  endfunction

  // one request transfer; start stays high when the next request follows at once
  task automatic send_request(input req_t r);
    int gap;
    gap = draw_gap();
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start <= 1'b1;
    req_i <= r;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    shadow.note_request(r);
  endtask

  // hold the sender off until every outstanding result has come back
  task automatic wait_for_results();
    start <= 1'b0;
    do @(posedge clk_i); while (shadow.expected_rsp.size() != 0);
  endtask

  initial begin
    req_t directed[$];
    mix_e mix;
    int   episode_len;
    int   random_sent;
    int   episode;

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed part: empty-set misses, signed extremes, duplicate, absent remove,
    // the unused action, and a full walk back down to empty
    directed.push_back(mk_req(ACT_LOOKUP, 32'sd5));
    directed.push_back(mk_req(ACT_REMOVE, 32'sd5));
    directed.push_back(mk_req(ACT_UNUSED, '0));
    directed.push_back(mk_req(ACT_INSERT, '0));
    directed.push_back(mk_req(ACT_INSERT, VAL_MIN));
    directed.push_back(mk_req(ACT_INSERT, VAL_MAX));
    directed.push_back(mk_req(ACT_INSERT, -32'sd1));
    directed.push_back(mk_req(ACT_INSERT, 32'sd1));
    directed.push_back(mk_req(ACT_INSERT, '0));
    directed.push_back(mk_req(ACT_LOOKUP, VAL_MIN));
    directed.push_back(mk_req(ACT_LOOKUP, VAL_MAX));
    directed.push_back(mk_req(ACT_LOOKUP, 32'sd2));
    directed.push_back(mk_req(ACT_REMOVE, -32'sd1));
    directed.push_back(mk_req(ACT_REMOVE, -32'sd1));
    directed.push_back(mk_req(ACT_UNUSED, VAL_MAX));
    directed.push_back(mk_req(ACT_INSERT, VAL_MAX - 1));
    directed.push_back(mk_req(ACT_REMOVE, VAL_MAX));
    directed.push_back(mk_req(ACT_REMOVE, VAL_MIN));
    directed.push_back(mk_req(ACT_LOOKUP, VAL_MIN));
    directed.push_back(mk_req(ACT_REMOVE, '0));
    directed.push_back(mk_req(ACT_REMOVE, 32'sd1));
    directed.push_back(mk_req(ACT_REMOVE, VAL_MAX - 1));
    directed.push_back(mk_req(ACT_LOOKUP, '0));
    foreach (directed[i]) send_request(directed[i]);

    // pause until the set and the block agree before random traffic starts
    wait_for_results();

    // random part: the first episode fills the table well past capacity so that
    // full-table rejects and duplicates at full are hit early
    random_sent = 0;
    episode     = 0;
    while (random_sent < RANDOM_ITEMS) begin
      if (episode == 0) begin
        mix         = MIX_FILL;
        episode_len = CAPACITY + 40;
      end else begin
        mix         = mix_e'($urandom_range(0, 2));
        episode_len = $urandom_range(20, 120);
      end
      for (int k = 0; k < episode_len && random_sent < RANDOM_ITEMS; k++) begin
        req_t r;
        r = pick_request(mix);
        send_request(r);
        if (r.action != ACT_UNUSED) random_sent++;
      end
      if ($urandom_range(0, 3) == 0) wait_for_results();
      episode++;
    end

    // drain: nothing outstanding, then let a full-table latency pass
    wait_for_results();
    repeat (TAIL_CYCLES) @(posedge clk_i);

    $display("covered %0d results: %0d inserts, %0d duplicates, %0d full rejects, %0d removes",
             shadow.n_checked, shadow.n_inserted, shadow.n_duplicate, shadow.n_rejected,
             shadow.n_removed);
    $display("  %0d hits, %0d misses, %0d no-ops, peak fill %0d of %0d",
             shadow.n_found, shadow.n_missed, shadow.n_noop, shadow.peak_fill, CAPACITY);
    if (shadow.failures == 0) begin
      $display("sorted_set_table_unit regression: pass");
    end else begin
      $display("sorted_set_table_unit regression: fail");
    end
    $finish;
  end

  // watchdog well above the slowest legal run
  initial begin
    #6_000_000;
    $display("sorted_set_table_unit regression: fail");
    $finish;
  end

endmodule
